>>> hw/rtl/cpa_pkg.sv
// Shared types and constants for the call profile accumulator.
// No dependencies; imported by cpa_slot_table, call_profile_accumulator and tb_top.
package cpa_pkg;

    localparam int unsigned CPA_STACK_DEPTH = 64;
    localparam int unsigned CPA_TABLE_SLOTS = 64;

    // command codes
    localparam logic [2:0] CMD_ENTER      = 3'd0;
    localparam logic [2:0] CMD_EXIT       = 3'd1;
    localparam logic [2:0] CMD_READ_SLOT  = 3'd2;
    localparam logic [2:0] CMD_READ_CNT   = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_ZERO_TIME  = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OVERFLOW    = 3'd1;
    localparam logic [2:0] ST_UNMATCHED   = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY_SLOT  = 3'd4;

    // interrupt kinds
    localparam logic [2:0] KIND_IRQ0      = 3'd2;
    localparam logic [2:0] KIND_NMI       = 3'd5;

    // counter numbers
    localparam logic [7:0] CNT_ELAPSED    = 8'd0;
    localparam logic [7:0] CNT_CALLS      = 8'd1;
    localparam logic [7:0] CNT_IRQS       = 8'd2;
    localparam logic [7:0] CNT_UNMATCHED  = 8'd3;
    localparam logic [7:0] CNT_MAX_DEPTH  = 8'd4;
    localparam logic [7:0] CNT_OVERFLOWS  = 8'd5;
    localparam logic [7:0] CNT_ENTRIES    = 8'd6;
    localparam logic [7:0] CNT_DROPS      = 8'd7;

    localparam int unsigned KEY_W = 19;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] call_addr;
        logic [2:0]  call_kind;
        logic        divergent;
        logic [31:0] cycle_now;
        logic [7:0]  select_index;
    } t_cpa_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] entry_addr;
        logic [2:0]  entry_kind;
        logic        entry_valid;
        logic [31:0] call_total;
        logic [63:0] inclusive_sum;
        logic [63:0] exclusive_sum;
        logic [63:0] inclusive_min;
        logic [63:0] inclusive_max;
        logic [63:0] counter_value;
        logic [6:0]  stack_depth;
    } t_cpa_res;

    // one statistics record of the slot table
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [31:0]      calls;
        logic [63:0]      incl;
        logic [63:0]      excl;
        logic [63:0]      min;
        logic [63:0]      max;
    } t_slot;

    typedef struct packed {
        logic clear;
        logic lookup;
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

    typedef struct packed {
        logic hit;
        logic found;
    } t_tbl_look;

endpackage

>>> hw/rtl/call_profile_accumulator.sv
// Call profile accumulator: frame stack memory, event counters and time base.
// Depends on cpa_pkg and cpa_slot_table.
// Requests go through dispatch; a matched exit then passes the frame read, table lookup and
// slot update states, a slot read passes a slot read state, and a table full drop leaves after
// the lookup. One request in flight; the next is taken in the cycle after the
// result moves to the output register, which lets a new request in while a result waits.
// Exit cost is set by the frame stack read, parent update and slot memory update.
// Reset clears control, counters, depth and slot valid bits; memories keep contents.
module call_profile_accumulator import cpa_pkg::*; #(
    parameter int unsigned STACK_DEPTH = CPA_STACK_DEPTH,
    parameter int unsigned TABLE_SLOTS = CPA_TABLE_SLOTS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_cpa_req i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_cpa_res o_out_res
);

    localparam int unsigned SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned FW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic [15:0] addr;
        logic [2:0]  kind;
        logic [63:0] entry;
    } t_frame;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_X_FRAME,
        S_X_LOOK,
        S_X_UPD,
        S_RDSLOT,
        S_DONE
    } t_state;

    t_state           r_state;
    t_cpa_req         r_req;
    logic             r_enable;
    logic [DW-1:0]    r_depth;
    logic [31:0]      r_high;
    logic [31:0]      r_last;
    logic [63:0]      r_anchor;
    logic [63:0]      r_cnt_calls;
    logic [63:0]      r_cnt_irqs;
    logic [63:0]      r_cnt_unm;
    logic [63:0]      r_cnt_maxd;
    logic [63:0]      r_cnt_ovf;
    logic [63:0]      r_cnt_drop;
    logic [63:0]      r_time;
    logic [63:0]      r_incl;
    logic [63:0]      r_excl;
    logic [63:0]      r_csum;
    logic [KEY_W-1:0] r_key;
    logic             r_new;
    logic [SW-1:0]    r_slot;
    t_cpa_res         r_res;
    logic             r_out_valid;
    t_cpa_res         r_out;

    t_frame           r_frame_mem [STACK_DEPTH];
    t_frame           r_frame_rd;
    logic [63:0]      r_child_mem [STACK_DEPTH];
    logic [63:0]      r_child_rd;

    logic [31:0]      n_high;
    logic [63:0]      w_full;
    logic [63:0]      w_time;
    logic [DW-1:0]    w_below;
    logic [DW-1:0]    w_depth_up;
    logic             w_stack_full;
    logic             w_enter_en;
    logic             w_exit_en;
    logic             w_exit_ok;
    logic             w_rd_hit;
    logic             w_handover;
    t_cpa_res         w_fin;

    logic             w_frame_we;
    logic             w_frame_re;
    t_frame           w_frame_wdata;
    logic             w_child_we;
    logic             w_child_re;
    logic [FW-1:0]    w_child_widx;
    logic [63:0]      w_child_wdata;

    t_tbl_ctl         w_tbl_ctl;
    t_tbl_look        w_look;
    logic [SW-1:0]    w_tbl_slot;
    t_slot            w_tbl_rd;
    logic             w_sel_used;
    logic [CW-1:0]    w_used_count;
    t_slot            w_base;
    t_slot            w_upd;
    logic [63:0]      w_cnt_val;
    logic [63:0]      w_incl;

    // extend the raw cycle count and take it relative to the anchor
    always_comb begin
        n_high = (r_req.cycle_now < r_last) ? r_high + 32'd1 : r_high;
        w_full = {n_high, r_req.cycle_now};
        w_time = (w_full < r_anchor) ? 64'd0 : w_full - r_anchor;
    end

    assign w_below      = r_depth - 1'b1;
    assign w_depth_up   = r_depth + 1'b1;
    assign w_stack_full = (int'(r_depth) >= STACK_DEPTH);
    assign w_enter_en   = (r_req.cmd == CMD_ENTER) && r_enable;
    assign w_exit_en    = (r_req.cmd == CMD_EXIT) && r_enable;
    assign w_exit_ok    = w_exit_en && !r_req.divergent && (r_depth != '0);
    assign w_rd_hit     = (r_req.cmd == CMD_READ_SLOT) && w_sel_used
                          && (int'(r_req.select_index) < TABLE_SLOTS);
    assign w_incl       = (r_time >= r_frame_rd.entry) ? r_time - r_frame_rd.entry : 64'd0;
    assign w_handover   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // attach the open frame count to the finished result
    always_comb begin
        w_fin             = r_res;
        w_fin.stack_depth = 7'(r_depth);
    end

    // frame stack port control
    always_comb begin
        w_frame_we          = (r_state == S_DISP) && w_enter_en && !w_stack_full;
        w_frame_re          = (r_state == S_DISP) && w_exit_ok;
        w_frame_wdata.addr  = r_req.call_addr;
        w_frame_wdata.kind  = r_req.call_kind;
        w_frame_wdata.entry = w_time;
        w_child_re          = w_frame_re || (r_state == S_X_FRAME);
        w_child_we          = w_frame_we || ((r_state == S_X_LOOK) && (r_depth != '0));
        w_child_widx        = w_frame_we ? r_depth[FW-1:0] : w_below[FW-1:0];
        w_child_wdata       = w_frame_we ? 64'd0 : r_child_rd + r_incl;
    end

    // frame stack memories
    always_ff @(posedge i_clk) begin
        if (w_frame_we) begin
            r_frame_mem[r_depth[FW-1:0]] <= w_frame_wdata;
        end
        if (w_frame_re) begin
            r_frame_rd <= r_frame_mem[w_below[FW-1:0]];
        end
        if (w_child_we) begin
            r_child_mem[w_child_widx] <= w_child_wdata;
        end
        if (w_child_re) begin
            r_child_rd <= r_child_mem[w_below[FW-1:0]];
        end
    end

    // slot table control
    always_comb begin
        w_tbl_ctl.clear  = (r_state == S_DISP) && (r_req.cmd == CMD_CLEAR);
        w_tbl_ctl.lookup = (r_state == S_X_LOOK);
        w_tbl_ctl.rd_en  = (r_state == S_DISP);
        w_tbl_ctl.wr_en  = (r_state == S_X_UPD);
    end

    cpa_slot_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_tbl_ctl),
        .i_key        (r_key),
        .i_rd_idx     (r_req.select_index[SW-1:0]),
        .i_wr_idx     (r_slot),
        .i_wr_data    (w_upd),
        .o_look       (w_look),
        .o_slot       (w_tbl_slot),
        .o_rd_data    (w_tbl_rd),
        .o_sel_used   (w_sel_used),
        .o_used_count (w_used_count)
    );

    // merge this call into the slot record
    always_comb begin
        if (r_new) begin
            w_base       = '0;
            w_base.min   = '1;
        end else begin
            w_base       = w_tbl_rd;
        end
        w_upd.key   = r_key;
        w_upd.calls = (w_base.calls == 32'hFFFF_FFFF) ? w_base.calls : w_base.calls + 32'd1;
        w_upd.incl  = w_base.incl + r_incl;
        w_upd.excl  = w_base.excl + r_excl;
        w_upd.min   = (r_incl < w_base.min) ? r_incl : w_base.min;
        w_upd.max   = (r_incl > w_base.max) ? r_incl : w_base.max;
    end

    // select a counter
    always_comb begin
        unique case (r_req.select_index)
            CNT_ELAPSED:   w_cnt_val = w_time;
            CNT_CALLS:     w_cnt_val = r_cnt_calls;
            CNT_IRQS:      w_cnt_val = r_cnt_irqs;
            CNT_UNMATCHED: w_cnt_val = r_cnt_unm;
            CNT_MAX_DEPTH: w_cnt_val = r_cnt_maxd;
            CNT_OVERFLOWS: w_cnt_val = r_cnt_ovf;
            CNT_ENTRIES:   w_cnt_val = 64'(w_used_count);
            CNT_DROPS:     w_cnt_val = r_cnt_drop;
            default:       w_cnt_val = 64'd0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // sequencer, counters, time base and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_depth     <= '0;
            r_high      <= '0;
            r_last      <= '0;
            r_anchor    <= '0;
            r_cnt_calls <= '0;
            r_cnt_irqs  <= '0;
            r_cnt_unm   <= '0;
            r_cnt_maxd  <= '0;
            r_cnt_ovf   <= '0;
            r_cnt_drop  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (w_handover) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_req;
                        r_res   <= '0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_state <= w_exit_ok ? S_X_FRAME : (w_rd_hit ? S_RDSLOT : S_DONE);
                    if (w_enter_en) begin
                        r_cnt_calls <= r_cnt_calls + 64'd1;
                        if (r_req.call_kind >= KIND_IRQ0 && r_req.call_kind <= KIND_NMI) begin
                            r_cnt_irqs <= r_cnt_irqs + 64'd1;
                        end
                        r_res.entry_addr <= r_req.call_addr;
                        r_res.entry_kind <= r_req.call_kind;
                        if (w_stack_full) begin
                            r_cnt_ovf    <= r_cnt_ovf + 64'd1;
                            r_res.status <= ST_OVERFLOW;
                        end else begin
                            r_high  <= n_high;
                            r_last  <= r_req.cycle_now;
                            r_depth <= w_depth_up;
                            if (64'(w_depth_up) > r_cnt_maxd) begin
                                r_cnt_maxd <= 64'(w_depth_up);
                            end
                        end
                    end else if (w_exit_en) begin
                        if (!w_exit_ok) begin
                            r_cnt_unm    <= r_cnt_unm + 64'd1;
                            r_res.status <= ST_UNMATCHED;
                        end else begin
                            r_depth <= w_below;
                            r_high  <= n_high;
                            r_last  <= r_req.cycle_now;
                            r_time  <= w_time;
                        end
                    end else begin
                        case (r_req.cmd)
                            CMD_READ_SLOT: begin
                                if (!w_rd_hit) begin
                                    r_res.status <= ST_EMPTY_SLOT;
                                end
                            end
                            CMD_READ_CNT: begin
                                r_res.counter_value <= w_cnt_val;
                                if (r_req.select_index == CNT_ELAPSED) begin
                                    r_high <= n_high;
                                    r_last <= r_req.cycle_now;
                                end
                            end
                            CMD_CLEAR: begin
                                r_depth     <= '0;
                                r_cnt_calls <= '0;
                                r_cnt_irqs  <= '0;
                                r_cnt_unm   <= '0;
                                r_cnt_maxd  <= '0;
                                r_cnt_ovf   <= '0;
                                r_cnt_drop  <= '0;
                                r_high      <= '0;
                                r_last      <= r_req.cycle_now;
                                r_anchor    <= 64'(r_req.cycle_now);
                            end
                            CMD_ZERO_TIME: begin
                                r_high   <= '0;
                                r_last   <= '0;
                                r_anchor <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_X_FRAME: begin
                    r_incl  <= w_incl;
                    r_csum  <= r_child_rd;
                    r_key   <= {r_frame_rd.kind, r_frame_rd.addr};
                    r_state <= S_X_LOOK;
                end
                S_X_LOOK: begin
                    r_excl <= (r_incl > r_csum) ? r_incl - r_csum : 64'd0;
                    r_new  <= !w_look.hit;
                    r_slot <= w_tbl_slot;
                    if (!w_look.found) begin
                        r_cnt_drop       <= r_cnt_drop + 64'd1;
                        r_res.status     <= ST_TABLE_FULL;
                        r_res.entry_addr <= r_key[15:0];
                        r_res.entry_kind <= r_key[18:16];
                        r_state          <= S_DONE;
                    end else begin
                        r_state <= S_X_UPD;
                    end
                end
                S_X_UPD: begin
                    r_res.entry_addr    <= w_upd.key[15:0];
                    r_res.entry_kind    <= w_upd.key[18:16];
                    r_res.entry_valid   <= 1'b1;
                    r_res.call_total    <= w_upd.calls;
                    r_res.inclusive_sum <= w_upd.incl;
                    r_res.exclusive_sum <= w_upd.excl;
                    r_res.inclusive_min <= (w_upd.calls != 32'd0) ? w_upd.min : 64'd0;
                    r_res.inclusive_max <= w_upd.max;
                    r_state             <= S_DONE;
                end
                S_RDSLOT: begin
                    r_res.entry_addr    <= w_tbl_rd.key[15:0];
                    r_res.entry_kind    <= w_tbl_rd.key[18:16];
                    r_res.entry_valid   <= 1'b1;
                    r_res.call_total    <= w_tbl_rd.calls;
                    r_res.inclusive_sum <= w_tbl_rd.incl;
                    r_res.exclusive_sum <= w_tbl_rd.excl;
                    r_res.inclusive_min <= (w_tbl_rd.calls != 32'd0) ? w_tbl_rd.min : 64'd0;
                    r_res.inclusive_max <= w_tbl_rd.max;
                    r_state             <= S_DONE;
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (w_handover) begin
                        r_out   <= w_fin;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_depth) <= STACK_DEPTH)
        else $error("open frame count beyond stack depth");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISP))
        else $error("accepted request not dispatched");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_X_LOOK && !w_look.found)
        |=> (r_state == S_DONE && r_res.status == ST_TABLE_FULL))
        else $error("table miss without free slot not reported as drop");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_used_count) <= TABLE_SLOTS)
        else $error("used slot count beyond table size");

endmodule

>>> hw/rtl/cpa_slot_table.sv
// Keyed slot table: valid bits and key match flops, plus statistics memory.
// Depends on cpa_pkg.
module cpa_slot_table import cpa_pkg::*; #(
    parameter int unsigned TABLE_SLOTS = CPA_TABLE_SLOTS,
    localparam int unsigned SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tbl_ctl         i_ctl,
    input  logic [KEY_W-1:0] i_key,
    input  logic [SW-1:0]    i_rd_idx,
    input  logic [SW-1:0]    i_wr_idx,
    input  t_slot            i_wr_data,
    output t_tbl_look        o_look,
    output logic [SW-1:0]    o_slot,
    output t_slot            o_rd_data,
    output logic             o_sel_used,
    output logic [CW-1:0]    o_used_count
);

    logic             r_used [TABLE_SLOTS];
    logic [KEY_W-1:0] r_key  [TABLE_SLOTS];
    logic [CW-1:0]    r_count;
    t_slot            r_mem  [TABLE_SLOTS];
    t_slot            r_rd;

    logic          w_hit;
    logic          w_free;
    logic [SW-1:0] w_hit_idx;
    logic [SW-1:0] w_free_idx;
    logic [SW-1:0] w_rd_addr;

    // match keys and find the first free slot, lowest index wins
    always_comb begin
        w_hit      = 1'b0;
        w_free     = 1'b0;
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (r_used[i] && (r_key[i] == i_key)) begin
                w_hit     = 1'b1;
                w_hit_idx = SW'(i);
            end
            if (!r_used[i]) begin
                w_free     = 1'b1;
                w_free_idx = SW'(i);
            end
        end
    end

    assign o_look.hit   = w_hit;
    assign o_look.found = w_hit || w_free;
    assign o_slot       = w_hit ? w_hit_idx : w_free_idx;
    assign w_rd_addr    = i_ctl.lookup ? o_slot : i_rd_idx;
    assign o_sel_used   = (int'(i_rd_idx) < TABLE_SLOTS) && r_used[i_rd_idx];
    assign o_used_count = r_count;
    assign o_rd_data    = r_rd;

    // claim a slot on a miss, empty the table on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
            r_count <= '0;
        end else if (i_ctl.clear) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
            r_count <= '0;
        end else if (i_ctl.lookup && !w_hit && w_free) begin
            r_used[w_free_idx] <= 1'b1;
            r_count            <= r_count + 1'b1;
        end
    end

    // hold keys of claimed slots
    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup && !w_hit && w_free) begin
            r_key[w_free_idx] <= i_key;
        end
    end

    // statistics memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_ctl.rd_en || i_ctl.lookup) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for call_profile_accumulator: random call trees, reads and clears.
// Depends on cpa_pkg and the call_profile_accumulator RTL; predicts every result in-bench.
`timescale 1ns / 100ps

module tb_top;
    import cpa_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 10;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_cfg_we = 1'b0;
    logic     i_cfg_wdata = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_cpa_req i_in_req = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_cpa_res o_out_res;

    call_profile_accumulator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    always #10 i_clk = ~i_clk;

    // pending requests and expected results
    t_cpa_req pend_q[$];
    t_cpa_res expect_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  send_pause = 1'b0;
    int  hold_req = 0;
    bit  req_taken = 1'b0;

    // predictor state
    bit          prof_en;
    logic [15:0] fr_addr[CPA_STACK_DEPTH];
    logic [2:0]  fr_kind[CPA_STACK_DEPTH];
    logic [63:0] fr_entry[CPA_STACK_DEPTH];
    logic [63:0] fr_child[CPA_STACK_DEPTH];
    int          depth;
    bit          sl_used[CPA_TABLE_SLOTS];
    logic [18:0] sl_key[CPA_TABLE_SLOTS];
    logic [31:0] sl_calls[CPA_TABLE_SLOTS];
    logic [63:0] sl_incl[CPA_TABLE_SLOTS];
    logic [63:0] sl_excl[CPA_TABLE_SLOTS];
    logic [63:0] sl_min[CPA_TABLE_SLOTS];
    logic [63:0] sl_max[CPA_TABLE_SLOTS];
    logic [31:0] hi_word;
    logic [31:0] last_raw;
    logic [63:0] anchor;
    logic [63:0] n_calls, n_irqs, n_unmatched, n_peak, n_over, n_drops;

    // generator state
    logic [31:0] gen_time = 32'd0;
    int          gen_depth = 0;
    int          gen_count = 0;
    logic [15:0] addr_pool[24];

    task automatic flag(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // extend raw count to 64 bits relative to the anchor
    function automatic logic [63:0] stamp(input logic [31:0] now);
        logic [63:0] full;
        if (now < last_raw)
            hi_word = hi_word + 1;
        last_raw = now;
        full = {hi_word, now};
        return (full < anchor) ? 64'd0 : full - anchor;
    endfunction

    function automatic void fill_slot(input int s, inout t_cpa_res o);
        o.entry_addr    = sl_key[s][15:0];
        o.entry_kind    = sl_key[s][18:16];
        o.entry_valid   = 1'b1;
        o.call_total    = sl_calls[s];
        o.inclusive_sum = sl_incl[s];
        o.exclusive_sum = sl_excl[s];
        o.inclusive_min = (sl_calls[s] != 0) ? sl_min[s] : 64'd0;
        o.inclusive_max = sl_max[s];
    endfunction

    function automatic void wipe_stats(input logic [31:0] now);
        for (int i = 0; i < CPA_TABLE_SLOTS; i++)
            sl_used[i] = 1'b0;
        depth = 0;
        {n_calls, n_irqs, n_unmatched, n_peak, n_over, n_drops} = '0;
        hi_word = 0;
        last_raw = now;
        anchor = {32'd0, now};
    endfunction

    // compute the result of one request and advance the profile state
    function automatic t_cpa_res profile_step(input t_cpa_req r);
        t_cpa_res    o;
        int          d;
        int          s;
        logic [63:0] t;
        logic [63:0] incl;
        logic [63:0] excl;
        logic [18:0] key;
        logic [63:0] v;
        o = '0;
        if (r.cmd == CMD_ENTER && prof_en) begin
            n_calls++;
            if (r.call_kind >= KIND_IRQ0 && r.call_kind <= KIND_NMI)
                n_irqs++;
            o.entry_addr = r.call_addr;
            o.entry_kind = r.call_kind;
            if (depth >= CPA_STACK_DEPTH) begin
                n_over++;
                o.status = ST_OVERFLOW;
            end else begin
                fr_addr[depth] = r.call_addr;
                fr_kind[depth] = r.call_kind;
                fr_entry[depth] = stamp(r.cycle_now);
                fr_child[depth] = 0;
                depth++;
                if (depth > n_peak)
                    n_peak = depth;
            end
        end else if (r.cmd == CMD_EXIT && prof_en) begin
            if (r.divergent || depth == 0) begin
                n_unmatched++;
                o.status = ST_UNMATCHED;
            end else begin
                d = depth - 1;
                depth = d;
                t = stamp(r.cycle_now);
                incl = (t >= fr_entry[d]) ? t - fr_entry[d] : 64'd0;
                excl = (incl > fr_child[d]) ? incl - fr_child[d] : 64'd0;
                if (d > 0)
                    fr_child[d-1] += incl;
                key = {fr_kind[d], fr_addr[d]};
                s = -1;
                for (int i = 0; i < CPA_TABLE_SLOTS; i++)
                    if (s < 0 && sl_used[i] && sl_key[i] == key)
                        s = i;
                if (s < 0) begin
                    for (int i = 0; i < CPA_TABLE_SLOTS; i++)
                        if (s < 0 && !sl_used[i])
                            s = i;
                    if (s >= 0) begin
                        sl_used[s] = 1'b1;
                        sl_key[s] = key;
                        sl_calls[s] = 0;
                        sl_incl[s] = 0;
                        sl_excl[s] = 0;
                        sl_min[s] = '1;
                        sl_max[s] = 0;
                    end
                end
                if (s < 0) begin
                    n_drops++;
                    o.status = ST_TABLE_FULL;
                    o.entry_addr = fr_addr[d];
                    o.entry_kind = fr_kind[d];
                end else begin
                    if (sl_calls[s] != 32'hFFFF_FFFF)
                        sl_calls[s]++;
                    sl_incl[s] += incl;
                    sl_excl[s] += excl;
                    if (incl < sl_min[s])
                        sl_min[s] = incl;
                    if (incl > sl_max[s])
                        sl_max[s] = incl;
                    fill_slot(s, o);
                end
            end
        end else if (r.cmd == CMD_READ_SLOT) begin
            if (r.select_index < CPA_TABLE_SLOTS && sl_used[r.select_index])
                fill_slot(r.select_index, o);
            else
                o.status = ST_EMPTY_SLOT;
        end else if (r.cmd == CMD_READ_CNT) begin
            v = 0;
            case (r.select_index)
                CNT_ELAPSED:   v = stamp(r.cycle_now);
                CNT_CALLS:     v = n_calls;
                CNT_IRQS:      v = n_irqs;
                CNT_UNMATCHED: v = n_unmatched;
                CNT_MAX_DEPTH: v = n_peak;
                CNT_OVERFLOWS: v = n_over;
                CNT_ENTRIES: begin
                    for (int i = 0; i < CPA_TABLE_SLOTS; i++)
                        v += sl_used[i];
                end
                CNT_DROPS:     v = n_drops;
                default:       v = 0;
            endcase
            o.counter_value = v;
        end else if (r.cmd == CMD_CLEAR) begin
            wipe_stats(r.cycle_now);
        end else if (r.cmd == CMD_ZERO_TIME) begin
            hi_word = 0;
            last_raw = 0;
            anchor = 0;
        end
        o.stack_depth = depth[6:0];
        return o;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // monitor: check results, predict on each accepted request
    always @(posedge i_clk) begin
        t_cpa_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expect_q.size() == 0) begin
                flag("result with no expectation");
            end else begin
                want = expect_q.pop_front();
                check_field("status", o_out_res.status, want.status);
                check_field("entry_addr", o_out_res.entry_addr, want.entry_addr);
                check_field("entry_kind", o_out_res.entry_kind, want.entry_kind);
                check_field("entry_valid", o_out_res.entry_valid, want.entry_valid);
                check_field("call_total", o_out_res.call_total, want.call_total);
                check_field("inclusive_sum", o_out_res.inclusive_sum, want.inclusive_sum);
                check_field("exclusive_sum", o_out_res.exclusive_sum, want.exclusive_sum);
                check_field("inclusive_min", o_out_res.inclusive_min, want.inclusive_min);
                check_field("inclusive_max", o_out_res.inclusive_max, want.inclusive_max);
                check_field("counter_value", o_out_res.counter_value, want.counter_value);
                check_field("stack_depth", o_out_res.stack_depth, want.stack_depth);
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expect_q.push_back(profile_step(i_in_req));
            req_taken = 1'b1;
        end
    end

    // driver: hold until accepted, then offer the next request or idle
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !req_taken)) begin
            req_taken = 1'b0;
            if (pend_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle) begin
                i_in_req <= pend_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus long hold-offs counted here
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_req <= hold_req - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic add(input logic [2:0] cmd, input logic [15:0] addr,
                       input logic [2:0] kind, input logic dv,
                       input logic [31:0] now, input logic [7:0] sel);
        t_cpa_req r;
        r.cmd = cmd;
        r.call_addr = addr;
        r.call_kind = kind;
        r.divergent = dv;
        r.cycle_now = now;
        r.select_index = sel;
        pend_q.push_back(r);
        gen_count++;
    endtask

    function automatic logic [31:0] tick();
        if ($urandom_range(99) < 3)
            gen_time = gen_time + $urandom();
        else
            gen_time = gen_time + $urandom_range(300);
        return gen_time;
    endfunction

    task automatic add_enter();
        logic [15:0] a;
        a = ($urandom_range(9) == 0) ? 16'($urandom()) : addr_pool[$urandom_range(23)];
        add(CMD_ENTER, a, 3'($urandom_range(7)), 1'b0, tick(), 8'($urandom()));
        gen_depth++;
    endtask

    task automatic add_exit(input logic dv);
        add(CMD_EXIT, 16'($urandom()), 3'($urandom()), dv, tick(), 8'($urandom()));
        if (gen_depth > 0 && !dv)
            gen_depth--;
    endtask

    // one call tree with random shape (exits sometimes divergent), a read, a clear, a time zero, or noise
    task automatic add_random_chunk();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            repeat ($urandom_range(2, 14)) begin
                if (gen_depth == 0 || $urandom_range(1) == 0)
                    add_enter();
                else
                    add_exit($urandom_range(19) == 0);
            end
            while (gen_depth > 0)
                add_exit(1'b0);
        end else if (pick < 70) begin
            add(CMD_READ_SLOT, 16'($urandom()), 3'($urandom()), 1'($urandom()), tick(),
                ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(70)));
        end else if (pick < 82) begin
            add(CMD_READ_CNT, 16'($urandom()), 3'($urandom()), 1'($urandom()), tick(),
                ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(9)));
        end else if (pick < 84) begin
            add(CMD_CLEAR, 16'($urandom()), 3'($urandom()), 1'($urandom()), tick(),
                8'($urandom()));
        end else if (pick < 86) begin
            gen_time = $urandom_range(1000);
            add(CMD_ZERO_TIME, 16'($urandom()), 3'($urandom()), 1'($urandom()),
                32'($urandom()), 8'($urandom()));
        end else begin
            // noise: any command, any field
            add(3'($urandom()), 16'($urandom()), 3'($urandom()), 1'($urandom()),
                32'($urandom()), 8'($urandom()));
            gen_depth = 0;
        end
    endtask

    // overflow the stack, then unwind it
    task automatic add_deep_burst();
        repeat (CPA_STACK_DEPTH + 4)
            add_enter();
        repeat (CPA_STACK_DEPTH + 6)
            add_exit(1'b0);
        gen_depth = 0;
    endtask

    // distinct keys to fill the table
    task automatic add_key_sweep();
        for (int i = 0; i < CPA_TABLE_SLOTS + 6; i++) begin
            add(CMD_ENTER, 16'(16'h4000 + i), 3'd6, 1'b0, tick(), 8'd0);
            add(CMD_EXIT, 16'd0, 3'd0, 1'b0, tick(), 8'd0);
        end
        add(CMD_READ_CNT, 16'd0, 3'd0, 1'b0, tick(), CNT_DROPS);
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || i_in_valid || expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input bit v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        prof_en = v;
    endtask

    task automatic run_phase(input int items);
        int stop;
        stop = gen_count + items;
        add_deep_burst();
        while (gen_count < stop)
            add_random_chunk();
    endtask

    initial begin
        prof_en = 1'b0;
        depth = 0;
        wipe_stats(32'd0);
        for (int i = 0; i < 24; i++)
            addr_pool[i] = 16'($urandom());
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled: enter and exit ignored
        add(CMD_ENTER, 16'h1234, 3'd0, 1'b0, 32'd5, 8'd0);
        add(CMD_EXIT, 16'h0, 3'd0, 1'b0, 32'd9, 8'd0);
        add(CMD_READ_CNT, 16'h0, 3'd0, 1'b0, 32'd12, CNT_CALLS);
        drain();
        write_enable(1'b1);

        // directed: field extremes, nesting, unmatched, reads, unused commands, clear, time zero, key sweep
        add(CMD_ENTER, 16'h0000, 3'd0, 1'b0, 32'd10, 8'd0);
        add(CMD_ENTER, 16'hFFFF, 3'd5, 1'b0, 32'd20, 8'd0);
        add(CMD_ENTER, 16'h8001, 3'd7, 1'b0, 32'hFFFF_FFF0, 8'd0);
        add(CMD_EXIT, 16'h0, 3'd0, 1'b0, 32'd4, 8'd0);
        add(CMD_EXIT, 16'h0, 3'd0, 1'b1, 32'd30, 8'd0);
        add(CMD_EXIT, 16'h0, 3'd0, 1'b0, 32'd40, 8'd0);
        add(CMD_EXIT, 16'h0, 3'd0, 1'b0, 32'd50, 8'd0);
        add(CMD_EXIT, 16'h0, 3'd0, 1'b0, 32'd60, 8'd0);
        add(CMD_READ_SLOT, 16'h0, 3'd0, 1'b0, 32'd61, 8'd0);
        add(CMD_READ_SLOT, 16'h0, 3'd0, 1'b0, 32'd62, 8'd63);
        add(CMD_READ_SLOT, 16'h0, 3'd0, 1'b0, 32'd63, 8'd255);
        add(CMD_READ_CNT, 16'h0, 3'd0, 1'b0, 32'd70, CNT_ELAPSED);
        add(CMD_READ_CNT, 16'h0, 3'd0, 1'b0, 32'd71, CNT_MAX_DEPTH);
        add(CMD_READ_CNT, 16'h0, 3'd0, 1'b0, 32'd72, CNT_ENTRIES);
        add(CMD_READ_CNT, 16'h0, 3'd0, 1'b0, 32'd73, 8'd255);
        add(3'd6, 16'hFFFF, 3'd7, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        add(3'd7, 16'hFFFF, 3'd7, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        add(CMD_CLEAR, 16'h0, 3'd0, 1'b0, 32'h8000_0000, 8'd0);
        add(CMD_READ_CNT, 16'h0, 3'd0, 1'b0, 32'h7000_0000, CNT_ELAPSED);
        add(CMD_ZERO_TIME, 16'h0, 3'd0, 1'b0, 32'd0, 8'd0);
        add(CMD_READ_CNT, 16'h0, 3'd0, 1'b0, 32'd100, CNT_ELAPSED);
        gen_time = 32'd200;
        add_key_sweep();
        drain();

        // sender busy, receiver sparse
        send_idle = 12;
        recv_idle = 51;
        run_phase(300);
        drain();

        // disabled stretch
        write_enable(1'b0);
        run_phase(60);
        drain();
        write_enable(1'b1);

        // sender sparse, receiver busy
        send_idle = 51;
        recv_idle = 12;
        run_phase(300);
        drain();

        // no idling, with a long receiver hold-off and a sender pause
        send_idle = 0;
        recv_idle = 0;
        add(CMD_CLEAR, 16'h0, 3'd0, 1'b0, tick(), 8'd0);
        run_phase(150);
        hold_req = 300;
        while (pend_q.size() != 0 || i_in_valid || expect_q.size() != 0)
            @(posedge i_clk);
        send_pause = 1'b1;
        run_phase(150);
        repeat (5) @(posedge i_clk);
        send_pause = 1'b0;
        drain();

        if (expect_q.size() != 0)
            flag("expectations left over");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
